/* hw/rtl/pfr_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the planar frame transform
// no dependencies

package pfr_pkg;

  localparam int unsigned DataW     = 16;
  localparam int unsigned OutW      = 18;
  localparam int unsigned QW        = 18;
  localparam int unsigned WW        = 34;
  localparam int unsigned RW        = 80;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned FracBitsDef = 12;

  typedef enum logic [1:0] {
    REG_LEFT_X  = 2'd0,
    REG_LEFT_Z  = 2'd1,
    REG_RIGHT_X = 2'd2,
    REG_RIGHT_Z = 2'd3
  } reg_idx_e;

  // one channel of the root search as it moves down the cell row
  typedef struct packed {
    logic                 valid;
    logic                 sgn;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] p;
    logic [WW-1:0]        w;
    logic [QW-1:0]        q;
  } lane_t;

endpackage

/* hw/rtl/pfr_front.sv */
`timescale 1ns / 1ps
// front pipeline: offsets, dot and cross products, squares, initial residues
// depends on pfr_pkg

module pfr_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  logic signed [pfr_pkg::DataW-1:0]  point_x_i,
  input  logic signed [pfr_pkg::DataW-1:0]  point_z_i,
  input  logic signed [pfr_pkg::DataW-1:0]  left_x_i,
  input  logic signed [pfr_pkg::DataW-1:0]  left_z_i,
  input  logic signed [pfr_pkg::DataW-1:0]  right_x_i,
  input  logic signed [pfr_pkg::DataW-1:0]  right_z_i,
  output pfr_pkg::lane_t                    lane_x_o,
  output pfr_pkg::lane_t                    lane_z_o
);

  logic [4:0] vld_q;

  logic signed [17:0] dx2_d, dz2_d, dx2_q, dz2_q;
  logic signed [16:0] vx_d, vz_d, vx_q, vz_q;

  logic signed [34:0] pxx_q, pzz_q, pzx_q, pxz_q;
  logic signed [33:0] vxx_q, vzz_q;

  logic signed [35:0] n0, n1;
  logic [35:0] mag0_q, mag1_q;
  logic        sg0_q, sg1_q, sg0_4q, sg1_4q;
  logic [pfr_pkg::WW-1:0] w3_q, w4_q;

  logic [35:0] s11x_q, s10x_q, s00x_q, s11z_q, s10z_q, s00z_q;

  logic signed [pfr_pkg::RW-1:0] sqx, sqz, wext;

  always_comb begin
    vx_d = {right_x_i[15], right_x_i} - {left_x_i[15], left_x_i};
    vz_d = {right_z_i[15], right_z_i} - {left_z_i[15], left_z_i};
    // coinciding ends fall back to the identity rotation
    if (vx_d == '0 && vz_d == '0) begin
      vx_d = 17'sd1;
    end
    dx2_d = {point_x_i[15], point_x_i, 1'b0} - {{2{left_x_i[15]}}, left_x_i}
          - {{2{right_x_i[15]}}, right_x_i};
    dz2_d = {point_z_i[15], point_z_i, 1'b0} - {{2{left_z_i[15]}}, left_z_i}
          - {{2{right_z_i[15]}}, right_z_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], take_i};
    end
  end

  assign n0 = {pxx_q[34], pxx_q} + {pzz_q[34], pzz_q};
  assign n1 = {pzx_q[34], pzx_q} - {pxz_q[34], pxz_q};

  always_ff @(posedge clk_i) begin
    dx2_q <= dx2_d;
    dz2_q <= dz2_d;
    vx_q  <= vx_d;
    vz_q  <= vz_d;

    pxx_q <= dx2_q * vx_q;
    pzz_q <= dz2_q * vz_q;
    pzx_q <= dz2_q * vx_q;
    pxz_q <= dx2_q * vz_q;
    vxx_q <= vx_q * vx_q;
    vzz_q <= vz_q * vz_q;

    sg0_q  <= n0[35];
    sg1_q  <= n1[35];
    mag0_q <= n0[35] ? 36'(-n0) : 36'(n0);
    mag1_q <= n1[35] ? 36'(-n1) : 36'(n1);
    w3_q   <= pfr_pkg::WW'(vxx_q) + pfr_pkg::WW'(vzz_q);

    // squares split into narrow partial products
    s11x_q <= mag0_q[35:18] * mag0_q[35:18];
    s10x_q <= mag0_q[35:18] * mag0_q[17:0];
    s00x_q <= mag0_q[17:0] * mag0_q[17:0];
    s11z_q <= mag1_q[35:18] * mag1_q[35:18];
    s10z_q <= mag1_q[35:18] * mag1_q[17:0];
    s00z_q <= mag1_q[17:0] * mag1_q[17:0];
    sg0_4q <= sg0_q;
    sg1_4q <= sg1_q;
    w4_q   <= w3_q;
  end

  always_comb begin
    wext = $signed({{(pfr_pkg::RW-pfr_pkg::WW){1'b0}}, w4_q});
    sqx  = ($signed({{(pfr_pkg::RW-36){1'b0}}, s11x_q}) <<< 36)
         + ($signed({{(pfr_pkg::RW-36){1'b0}}, s10x_q}) <<< 19)
         +  $signed({{(pfr_pkg::RW-36){1'b0}}, s00x_q});
    sqz  = ($signed({{(pfr_pkg::RW-36){1'b0}}, s11z_q}) <<< 36)
         + ($signed({{(pfr_pkg::RW-36){1'b0}}, s10z_q}) <<< 19)
         +  $signed({{(pfr_pkg::RW-36){1'b0}}, s00z_q});
  end

  // residue n^2 - w*c^2 with c = -1, weighted term w*c
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_x_o <= '0;
      lane_z_o <= '0;
    end else begin
      lane_x_o.valid <= vld_q[3];
      lane_x_o.sgn   <= sg0_4q;
      lane_x_o.r     <= sqx - wext;
      lane_x_o.p     <= -wext;
      lane_x_o.w     <= w4_q;
      lane_x_o.q     <= '0;
      lane_z_o.valid <= vld_q[3];
      lane_z_o.sgn   <= sg1_4q;
      lane_z_o.r     <= sqz - wext;
      lane_z_o.p     <= -wext;
      lane_z_o.w     <= w4_q;
      lane_z_o.q     <= '0;
    end
  end

endmodule

/* hw/rtl/pfr_cell.sv */
`timescale 1ns / 1ps
// one cell of the rounding root search: settles quotient bit K
// depends on pfr_pkg

module pfr_cell #(
  parameter int unsigned K = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pfr_pkg::lane_t lane_i,
  output pfr_pkg::lane_t lane_o
);

  logic signed [pfr_pkg::RW-1:0] wk, t;
  logic                          hit;
  pfr_pkg::lane_t                lane_d;

  // trying c + 2^(K+1): residue drops by 2^(K+2) * (w*c + 2^K * w)
  always_comb begin
    wk     = $signed({{(pfr_pkg::RW-pfr_pkg::WW){1'b0}}, lane_i.w}) <<< K;
    t      = (lane_i.p + wk) <<< (K + 2);
    hit    = (t <= lane_i.r);
    lane_d = lane_i;
    if (hit) begin
      lane_d.r    = lane_i.r - t;
      lane_d.p    = lane_i.p + (wk <<< 1);
      lane_d.q[K] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_o <= '0;
    end else begin
      lane_o <= lane_d;
    end
  end

  a_valid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_o.valid == $past(lane_i.valid))
    else $error("cell valid lost or invented");

  a_res_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_o.valid && lane_o.q[K]) |-> (lane_o.r >= 0))
    else $error("residue negative after accepted bit");

  a_low_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_i.valid |-> ((lane_i.q & ((pfr_pkg::QW'(1) << (K + 1)) - 1'b1)) == '0))
    else $error("lower quotient bits set too early");

endmodule

/* hw/rtl/planar_frame_translate_rotate.sv */
`timescale 1ns / 1ps
// planar_frame_translate_rotate: maps a point into the frame of a two-ended array
// usage: pulse start_i with point_x_i/point_z_i; busy_o stays low, so a new
//   beat may be started in every cycle
// the array ends are set over the apb port (left_x, left_z, right_x, right_z at
//   byte addresses 0, 4, 8, 12); write them only while no point is in flight
// each result beat shows on frame_x_o/frame_z_o for one cycle with valid_o high;
//   one result per cycle sustained
// the pipeline is five front stages (offsets, products, magnitudes, squares, residues),
//   a row of 18 cells that each settle one result bit, and an output register
// results are rounded to nearest (ties away from zero) and saturated to 18 bits
// reset clears the pipeline valids and loads the ends (0,0) and (1.0,0)
// the receiver cannot stall: every result beat is taken in its cycle
// depends on pfr_pkg, pfr_front, pfr_cell

module planar_frame_translate_rotate #(
  parameter int unsigned FRAC_BITS = pfr_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [pfr_pkg::DataW-1:0]  point_x_i,
  input  logic signed [pfr_pkg::DataW-1:0]  point_z_i,
  output logic                              valid_o,
  output logic signed [pfr_pkg::OutW-1:0]   frame_x_o,
  output logic signed [pfr_pkg::OutW-1:0]   frame_z_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pfr_pkg::AddrW-1:0]         paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam logic [pfr_pkg::DataW-1:0] OneVal = pfr_pkg::DataW'(1 << FRAC_BITS);

  logic signed [pfr_pkg::DataW-1:0] lx_q, lz_q, rx_q, rz_q;
  pfr_pkg::reg_idx_e                idx;
  logic                             wr_en;

  pfr_pkg::lane_t chx [pfr_pkg::QW+1];
  pfr_pkg::lane_t chz [pfr_pkg::QW+1];

  logic                               vld_q;
  logic signed [pfr_pkg::OutW-1:0]    fx_q, fz_q;

  assign busy_o = 1'b0;
  assign pready = 1'b1;
  assign idx    = pfr_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0;
      lz_q <= '0;
      rx_q <= OneVal;
      rz_q <= '0;
    end else if (wr_en) begin
      case (idx)
        pfr_pkg::REG_LEFT_X:  lx_q <= pwdata[15:0];
        pfr_pkg::REG_LEFT_Z:  lz_q <= pwdata[15:0];
        pfr_pkg::REG_RIGHT_X: rx_q <= pwdata[15:0];
        pfr_pkg::REG_RIGHT_Z: rz_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pfr_pkg::REG_LEFT_X:  prdata = {{16{lx_q[15]}}, lx_q};
      pfr_pkg::REG_LEFT_Z:  prdata = {{16{lz_q[15]}}, lz_q};
      pfr_pkg::REG_RIGHT_X: prdata = {{16{rx_q[15]}}, rx_q};
      pfr_pkg::REG_RIGHT_Z: prdata = {{16{rz_q[15]}}, rz_q};
      default:              prdata = '0;
    endcase
  end

  pfr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (start_i && !busy_o),
    .point_x_i (point_x_i),
    .point_z_i (point_z_i),
    .left_x_i  (lx_q),
    .left_z_i  (lz_q),
    .right_x_i (rx_q),
    .right_z_i (rz_q),
    .lane_x_o  (chx[0]),
    .lane_z_o  (chz[0])
  );

  // most significant result bit first
  for (genvar i = 0; i < pfr_pkg::QW; i++) begin : g_row
    pfr_cell #(.K(pfr_pkg::QW - 1 - i)) u_cell_x (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .lane_i (chx[i]),
      .lane_o (chx[i+1])
    );
    pfr_cell #(.K(pfr_pkg::QW - 1 - i)) u_cell_z (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .lane_i (chz[i]),
      .lane_o (chz[i+1])
    );
  end

  function automatic logic signed [pfr_pkg::OutW-1:0] sat_out(
    input logic sgn, input logic [pfr_pkg::QW-1:0] q
  );
    logic signed [pfr_pkg::QW:0] v;
    v = sgn ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > $signed((pfr_pkg::QW+1)'((1 << (pfr_pkg::OutW-1)) - 1))) begin
      sat_out = {1'b0, {(pfr_pkg::OutW-1){1'b1}}};
    end else if (v < -$signed((pfr_pkg::QW+1)'(1 << (pfr_pkg::OutW-1)))) begin
      sat_out = {1'b1, {(pfr_pkg::OutW-1){1'b0}}};
    end else begin
      sat_out = v[pfr_pkg::OutW-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= chx[pfr_pkg::QW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q <= sat_out(chx[pfr_pkg::QW].sgn, chx[pfr_pkg::QW].q);
    fz_q <= sat_out(chz[pfr_pkg::QW].sgn, chz[pfr_pkg::QW].q);
  end

  assign valid_o   = vld_q;
  assign frame_x_o = fx_q;
  assign frame_z_o = fz_q;

endmodule

/* tb/sv/planar_frame_translate_rotate_test.sv */
`timescale 1ns / 1ps
// self-checking bench for planar_frame_translate_rotate: random and corner points
// over several array-end settings, predicted by exact integer rounding
// depends on pfr_pkg and planar_frame_translate_rotate

module planar_frame_translate_rotate_test;

  localparam int Latency  = 24;
  localparam int DogLimit = 5000;

  class frame_scoreboard;
    longint lx, lz, rx, rz;
    logic signed [pfr_pkg::OutW-1:0] fx_q[$];
    logic signed [pfr_pkg::OutW-1:0] fz_q[$];
    int mismatches;

    function new();
      lx = 0; lz = 0; rx = 4096; rz = 0;
      mismatches = 0;
    endfunction

    function void set_end(pfr_pkg::reg_idx_e idx, logic signed [pfr_pkg::DataW-1:0] v);
      case (idx)
        pfr_pkg::REG_LEFT_X:  lx = v;
        pfr_pkg::REG_LEFT_Z:  lz = v;
        pfr_pkg::REG_RIGHT_X: rx = v;
        pfr_pkg::REG_RIGHT_Z: rz = v;
        default: ;
      endcase
    endfunction

    // round(n / sqrt(m)), ties away from zero, then clamp to 18 bits
    function logic signed [pfr_pkg::OutW-1:0] scaled_round(longint n, longint m);
      bit [127:0] th, a, p;
      longint mag, lo, hi, q;
      mag = n < 0 ? -n : n;
      th = 128'(2 * mag) * 128'(2 * mag);
      lo = 0;
      hi = 1 << 18;
      while (lo < hi) begin
        q = (lo + hi + 1) / 2;
        a = 128'(2 * q - 1);
        p = a * a * 128'(m);
        if (p <= th) lo = q;
        else hi = q - 1;
      end
      if (n < 0) lo = -lo;
      if (lo > 131071) lo = 131071;
      if (lo < -131072) lo = -131072;
      return lo[pfr_pkg::OutW-1:0];
    endfunction

    function void note_point(logic signed [pfr_pkg::DataW-1:0] px,
                             logic signed [pfr_pkg::DataW-1:0] pz);
      longint dx2, dz2, vx, vz, m;
      dx2 = 2 * longint'(px) - lx - rx;
      dz2 = 2 * longint'(pz) - lz - rz;
      vx = rx - lx;
      vz = rz - lz;
      // coinciding ends fall back to the identity rotation
      if (vx == 0 && vz == 0) vx = 1;
      m = 4 * (vx * vx + vz * vz);
      fx_q.push_back(scaled_round(dx2 * vx + dz2 * vz, m));
      fz_q.push_back(scaled_round(dz2 * vx - dx2 * vz, m));
    endfunction

    function void check_result(logic signed [pfr_pkg::OutW-1:0] fx,
                               logic signed [pfr_pkg::OutW-1:0] fz);
      logic signed [pfr_pkg::OutW-1:0] ex, ez;
      if (fx_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat x=%0d z=%0d", fx, fz);
        return;
      end
      ex = fx_q.pop_front();
      ez = fz_q.pop_front();
      if (fx !== ex || fz !== ez) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame mismatch: expected x=%0d z=%0d, got x=%0d z=%0d", ex, ez, fx, fz);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [pfr_pkg::DataW-1:0] point_x_i = '0;
  logic signed [pfr_pkg::DataW-1:0] point_z_i = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [pfr_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy_o, valid_o, pready;
  logic signed [pfr_pkg::OutW-1:0] frame_x_o, frame_z_o;
  logic [31:0] prdata;

  frame_scoreboard sb = new();
  int idle_pct;
  int dog = 0;

  planar_frame_translate_rotate dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // outputs and accepted beats are sampled mid-cycle, clear of edge updates
  always @(negedge clk_i) begin
    logic seen;
    seen = 1'b0;
    if (rst_ni && start_i && !busy_o) begin
      sb.note_point(point_x_i, point_z_i);
      seen = 1'b1;
    end
    if (rst_ni && valid_o) begin
      sb.check_result(frame_x_o, frame_z_o);
      seen = 1'b1;
    end
    if (seen) dog = 0;
    else dog = dog + 1;
    if (dog >= DogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_end(pfr_pkg::reg_idx_e idx, logic signed [pfr_pkg::DataW-1:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= pfr_pkg::AddrW'(4 * int'(idx));
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_end(idx, v);
  endtask

  task automatic set_ends(int a, int b, int c, int d);
    write_end(pfr_pkg::REG_LEFT_X, a[pfr_pkg::DataW-1:0]);
    write_end(pfr_pkg::REG_LEFT_Z, b[pfr_pkg::DataW-1:0]);
    write_end(pfr_pkg::REG_RIGHT_X, c[pfr_pkg::DataW-1:0]);
    write_end(pfr_pkg::REG_RIGHT_Z, d[pfr_pkg::DataW-1:0]);
  endtask

  // one beat, with random idle cycles ahead of it; caller sits at a posedge
  task automatic send_point(logic signed [pfr_pkg::DataW-1:0] px,
                            logic signed [pfr_pkg::DataW-1:0] pz);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    point_x_i <= px;
    point_z_i <= pz;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
  endtask

  // caller sits at the edge that took the last beat
  task automatic drain();
    start_i <= 1'b0;
    while (sb.fx_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 6) @(posedge clk_i);
  endtask

  task automatic run_phase(int n);
    send_point(16'sh0000, 16'sh0000);
    send_point(16'sh8000, 16'sh8000);
    send_point(16'sh7fff, 16'sh7fff);
    send_point(16'sh8000, 16'sh7fff);
    send_point(16'sh7fff, 16'sh8000);
    send_point(16'sh0001, 16'sh0000);
    send_point(-16'sh0001, 16'sh0000);
    send_point(16'sh0000, 16'sh0001);
    send_point(16'sh0000, -16'sh0001);
    repeat (n) begin
      if ($urandom_range(3) == 0) begin
        send_point(pfr_pkg::DataW'($urandom_range(511) - 256),
                   pfr_pkg::DataW'($urandom_range(511) - 256));
      end else begin
        send_point(pfr_pkg::DataW'($urandom), pfr_pkg::DataW'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    int idles[4] = '{0, 73, 28, 0};
    idle_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset ends first
    run_phase(300);
    idle_pct = 73;
    set_ends(-32768, -32768, 32767, 32767);
    run_phase(300);
    idle_pct = 28;
    set_ends(32767, 32767, -32768, -32768);
    run_phase(300);
    // coinciding ends
    idle_pct = 0;
    set_ends(100, -200, 100, -200);
    run_phase(200);
    // midpoint on half an lsb
    idle_pct = 73;
    set_ends(0, 0, 1, 0);
    run_phase(200);
    idle_pct = 0;
    set_ends(-3, 7, 4, -2);
    run_phase(200);
    for (int k = 0; k < 4; k++) begin
      idle_pct = idles[k];
      set_ends($urandom, $urandom, $urandom, $urandom);
      run_phase(100);
    end

    if (sb.mismatches == 0 && sb.fx_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_front.sv
hw/rtl/pfr_cell.sv
hw/rtl/planar_frame_translate_rotate.sv
tb/sv/planar_frame_translate_rotate_test.sv
